// ===== hdl/ole_pkg.sv =====
// Shared sizes and operation codes for the ordered list engine.
`timescale 1ns / 1ps

package ole_pkg;

  // List geometry
  localparam int CAPACITY   = 16;
  localparam int VALUE_BITS = 4;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int POS_W      = 4;
  localparam int KIND_W     = 2;

  // Operation codes carried in the kind field
  localparam logic [KIND_W-1:0] KIND_APPEND  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GET_POS = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GET_VAL = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd3;

endpackage

// ===== hdl/ole_in_if.sv =====
// Request channel of the ordered list engine: valid/ready plus operation fields.
`timescale 1ns / 1ps

interface ole_in_if import ole_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     kind;
  logic [VALUE_BITS-1:0] item_value;
  logic [POS_W-1:0]      position;
  logic                  remove;

  modport source (output valid, kind, item_value, position, remove, input ready);
  modport sink   (input valid, kind, item_value, position, remove, output ready);
endinterface

// ===== hdl/ole_out_if.sv =====
// Result channel of the ordered list engine: valid/ready plus result fields.
`timescale 1ns / 1ps

interface ole_out_if import ole_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] found_value;
  logic                  found;
  logic                  overflow;
  logic [CNT_W-1:0]      entry_count;

  modport source (output valid, found_value, found, overflow, entry_count, input ready);
  modport sink   (input valid, found_value, found, overflow, entry_count, output ready);
endinterface

// ===== hdl/ordered_list_engine.sv =====
// Ordered list engine: insertion-ordered list held in one synchronous memory.
`timescale 1ns / 1ps

// The list lives in a 16 x 4-bit memory with one write port and one read
// port whose data is registered, plus a count register; nothing needs a
// clearing pass after reset, since only entries below the count are read.
// One operation is in flight at a time; the next beat is taken once the
// current one has handed its result to the output register, which may still
// be waiting on out_chan.ready. Append and clear complete in S_IDLE as
// they are accepted; get by position reads the entry through S_POS on a hit
// and completes in S_IDLE on a miss. Get by value walks the list in S_SCAN
// through the single read port, one entry per cycle, up to the first match or
// the tail; an empty list completes in S_IDLE. A removal then closes the gap
// one entry per cycle through the same port in S_SHIFT. The result goes to
// the output register when the operation completes, or waits in S_EMIT for room.
module ordered_list_engine
  import ole_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  ole_in_if.sink    in_chan,
  ole_out_if.source out_chan
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_POS   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO_CNT = CNT_W'(2);

  // Entry storage
  logic [VALUE_BITS-1:0] mem [CAPACITY];
  logic [VALUE_BITS-1:0] rd_data_r;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [VALUE_BITS-1:0] wr_data;

  // Control state
  logic [2:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      ptr_r, ptr_nxt;
  logic [VALUE_BITS-1:0] key_r, key_nxt;
  logic                  remove_r, remove_nxt;

  // Pending result
  logic [VALUE_BITS-1:0] res_fv_r, res_fv_nxt;
  logic                  res_found_r, res_found_nxt;
  logic                  res_ovf_r, res_ovf_nxt;

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0] out_fv_r, out_fv_nxt;
  logic                  out_found_r, out_found_nxt;
  logic                  out_ovf_r, out_ovf_nxt;
  logic [CNT_W-1:0]      out_cnt_r, out_cnt_nxt;

  logic                  accept;
  logic                  out_free;
  logic                  fin;
  logic [VALUE_BITS-1:0] fin_fv;
  logic                  fin_found;
  logic                  fin_ovf;
  logic                  load_out;
  logic [CNT_W-1:0]      ptr_inc;
  logic [CNT_W-1:0]      ptr_inc2;
  logic [CNT_W-1:0]      pos_cnt;

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;
  assign ptr_inc       = ptr_r + ONE_CNT;
  assign ptr_inc2      = ptr_r + TWO_CNT;
  assign pos_cnt       = CNT_W'(in_chan.position);

  // Sequence one operation through the memory
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    key_nxt       = key_r;
    remove_nxt    = remove_r;
    res_fv_nxt    = res_fv_r;
    res_found_nxt = res_found_r;
    res_ovf_nxt   = res_ovf_r;
    wr_en         = 1'b0;
    wr_addr       = ptr_r[IDX_W-1:0];
    wr_data       = rd_data_r;
    rd_addr       = '0;
    fin           = 1'b0;
    fin_fv        = '0;
    fin_found     = 1'b0;
    fin_ovf       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          remove_nxt = in_chan.remove;
          key_nxt    = in_chan.item_value;
          case (in_chan.kind)
            KIND_APPEND: begin
              fin = 1'b1;
              if (count_r < CAP_CNT) begin
                wr_en     = 1'b1;
                wr_addr   = count_r[IDX_W-1:0];
                wr_data   = in_chan.item_value;
                count_nxt = count_r + ONE_CNT;
              end else begin
                fin_ovf = 1'b1;
              end
            end
            KIND_GET_POS: begin
              if (pos_cnt < count_r) begin
                rd_addr   = pos_cnt[IDX_W-1:0];
                ptr_nxt   = pos_cnt;
                state_nxt = S_POS;
              end else begin
                fin = 1'b1;
              end
            end
            KIND_GET_VAL: begin
              if (count_r != '0) begin
                rd_addr   = '0;
                ptr_nxt   = '0;
                state_nxt = S_SCAN;
              end else begin
                fin = 1'b1;
              end
            end
            default: begin
              // clear all
              count_nxt = '0;
              fin       = 1'b1;
            end
          endcase
        end
      end

      S_POS, S_SCAN: begin
        if (state_r == S_POS || rd_data_r == key_r) begin
          // hit: report it, or close the gap first when removing
          res_fv_nxt    = rd_data_r;
          res_found_nxt = 1'b1;
          res_ovf_nxt   = 1'b0;
          if (!remove_r) begin
            fin       = 1'b1;
            fin_fv    = rd_data_r;
            fin_found = 1'b1;
          end else if (ptr_inc < count_r) begin
            rd_addr   = ptr_inc[IDX_W-1:0];
            state_nxt = S_SHIFT;
          end else begin
            count_nxt = count_r - ONE_CNT;
            fin       = 1'b1;
            fin_fv    = rd_data_r;
            fin_found = 1'b1;
          end
        end else if (ptr_inc < count_r) begin
          // advance the scan by one entry
          rd_addr = ptr_inc[IDX_W-1:0];
          ptr_nxt = ptr_inc;
        end else begin
          fin = 1'b1;
        end
      end

      S_SHIFT: begin
        // move the entry read last cycle down one slot
        wr_en   = 1'b1;
        wr_addr = ptr_r[IDX_W-1:0];
        wr_data = rd_data_r;
        if (ptr_inc2 < count_r) begin
          rd_addr = ptr_inc2[IDX_W-1:0];
          ptr_nxt = ptr_inc;
        end else begin
          count_nxt = count_r - ONE_CNT;
          fin       = 1'b1;
          fin_fv    = res_fv_r;
          fin_found = 1'b1;
        end
      end

      S_EMIT: begin
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Hand the result to the output register, or hold it until there is room
    load_out    = 1'b0;
    out_fv_nxt    = out_fv_r;
    out_found_nxt = out_found_r;
    out_ovf_nxt   = out_ovf_r;
    out_cnt_nxt   = out_cnt_r;
    if (fin) begin
      res_fv_nxt    = fin_fv;
      res_found_nxt = fin_found;
      res_ovf_nxt   = fin_ovf;
      if (out_free) begin
        load_out      = 1'b1;
        out_fv_nxt    = fin_fv;
        out_found_nxt = fin_found;
        out_ovf_nxt   = fin_ovf;
        out_cnt_nxt   = count_nxt;
        state_nxt     = S_IDLE;
      end else begin
        state_nxt = S_EMIT;
      end
    end else if (state_r == S_EMIT && out_free) begin
      load_out      = 1'b1;
      out_fv_nxt    = res_fv_r;
      out_found_nxt = res_found_r;
      out_ovf_nxt   = res_ovf_r;
      out_cnt_nxt   = count_r;
      state_nxt     = S_IDLE;
    end

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    key_r       <= key_nxt;
    remove_r    <= remove_nxt;
    res_fv_r    <= res_fv_nxt;
    res_found_r <= res_found_nxt;
    res_ovf_r   <= res_ovf_nxt;
    out_fv_r    <= out_fv_nxt;
    out_found_r <= out_found_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.found_value = out_fv_r;
  assign out_chan.found       = out_found_r;
  assign out_chan.overflow    = out_ovf_r;
  assign out_chan.entry_count = out_cnt_r;

  // Checks on list bookkeeping
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("entry count above capacity");

  a_write_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> CNT_W'(wr_addr) <= count_r)
    else $error("memory write beyond the list tail");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_chan.kind == KIND_APPEND && count_r < CAP_CNT)
      |=> count_r == $past(count_r) + ONE_CNT)
    else $error("append did not grow the list by one");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_chan.kind == KIND_CLEAR) |=> count_r == '0)
    else $error("clear left entries behind");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && state_nxt != S_SHIFT) |-> count_nxt == count_r - ONE_CNT)
    else $error("gap close did not drop exactly one entry");

endmodule

// ===== sim/ole_checker.sv =====
// Scoreboard for the ordered list engine: predicts each result and compares beats.
`timescale 1ns / 1ps

module ole_checker
  import ole_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ole_in_if    req_mon,
  ole_out_if   rsp_mon,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    logic [VALUE_BITS-1:0] found_value;
    logic                  found;
    logic                  overflow;
    logic [CNT_W-1:0]      entry_count;
  } list_result_t;

  // Shadow copy of the list contents and its length
  logic [VALUE_BITS-1:0] shadow_row [CAPACITY];
  int unsigned           shadow_len;
  list_result_t          expected_results [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("checker: %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Remove one entry and shift the tail down over it
  function automatic void close_gap(int unsigned at);
    for (int unsigned i = at; i + 1 < shadow_len; i++)
      shadow_row[i] = shadow_row[i + 1];
    shadow_len--;
  endfunction

  // Apply one operation to the shadow list and return its result
  function automatic list_result_t apply_list_op(logic [KIND_W-1:0]     kind,
                                                 logic [VALUE_BITS-1:0] key,
                                                 logic [POS_W-1:0]      pos,
                                                 logic                  rem);
    list_result_t res;
    res = '0;
    case (kind)
      KIND_APPEND: begin
        if (shadow_len < CAPACITY) begin
          shadow_row[shadow_len] = key;
          shadow_len++;
        end else begin
          res.overflow = 1'b1;
        end
      end
      KIND_GET_POS: begin
        if (pos < shadow_len) begin
          res.found_value = shadow_row[pos];
          res.found       = 1'b1;
          if (rem)
            close_gap(pos);
        end
      end
      KIND_GET_VAL: begin
        // First match wins
        for (int unsigned i = 0; i < shadow_len; i++) begin
          if (shadow_row[i] == key) begin
            res.found_value = shadow_row[i];
            res.found       = 1'b1;
            if (rem)
              close_gap(i);
            break;
          end
        end
      end
      KIND_CLEAR: begin
        shadow_len = 0;
      end
      default: ;
    endcase
    res.entry_count = CNT_W'(shadow_len);
    return res;
  endfunction

  // Predict on each request beat, then check each result beat in order
  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      shadow_len = 0;
      expected_results.delete();
    end else begin
      if (req_mon.valid && req_mon.ready)
        expected_results.push_back(apply_list_op(req_mon.kind, req_mon.item_value,
                                                 req_mon.position, req_mon.remove));
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing outstanding", rsp_mon.entry_count, -1);
        end else begin
          want = expected_results.pop_front();
          if (rsp_mon.found_value !== want.found_value)
            report_mismatch("found_value", rsp_mon.found_value, want.found_value);
          if (rsp_mon.found !== want.found)
            report_mismatch("found", rsp_mon.found, want.found);
          if (rsp_mon.overflow !== want.overflow)
            report_mismatch("overflow", rsp_mon.overflow, want.overflow);
          if (rsp_mon.entry_count !== want.entry_count)
            report_mismatch("entry_count", rsp_mon.entry_count, want.entry_count);
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

// ===== sim/testbench.sv =====
// Top-level bench for the ordered list engine: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import ole_pkg::*;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   errors;
  int   pending;
  bit   idle_on = 1'b1;
  int   results_taken = 0;

  ole_in_if  req_chan ();
  ole_out_if rsp_chan ();

  ordered_list_engine uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_chan),
    .out_chan (rsp_chan)
  );

  ole_checker list_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .req_mon (req_chan),
    .rsp_mon (rsp_chan),
    .errors  (errors),
    .pending (pending)
  );

  always #5 clk = ~clk;

  function automatic int draw_gap();
    return idle_on ? $urandom_range(0, 11) : 0;
  endfunction

  // Offer one request beat after a random gap and hold it until taken
  task automatic send_op(logic [KIND_W-1:0] kind, logic [VALUE_BITS-1:0] val,
                         logic [POS_W-1:0] pos, logic rem);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      req_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_chan.valid      <= 1'b1;
    req_chan.kind       <= kind;
    req_chan.item_value <= val;
    req_chan.position   <= pos;
    req_chan.remove     <= rem;
    @(posedge clk);
    while (!req_chan.ready) @(posedge clk);
  endtask

  // Pause the sender until every outstanding result has come back
  task automatic wait_drained();
    req_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off to back up the block
  initial begin
    int stall;
    rsp_chan.ready <= 1'b0;
    wait (rst_n);
    forever begin
      stall = draw_gap();
      if (results_taken == 250)
        stall = 120;
      if (stall > 0) begin
        rsp_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_chan.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_chan.valid) @(posedge clk);
      results_taken++;
    end
  end

  // Stimulus and verdict
  initial begin
    logic [KIND_W-1:0]     kind;
    logic [VALUE_BITS-1:0] val;
    logic [POS_W-1:0]      pos;
    int                    pick;
    int                    append_pct;
    int                    key_span;

    req_chan.valid      <= 1'b0;
    req_chan.kind       <= KIND_APPEND;
    req_chan.item_value <= '0;
    req_chan.position   <= '0;
    req_chan.remove     <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Misses on an empty list, remove requested
    send_op(KIND_GET_POS, 4'd0, 4'd0, 1'b1);
    send_op(KIND_GET_VAL, 4'd5, 4'd0, 1'b1);
    send_op(KIND_CLEAR, 4'd0, 4'd0, 1'b0);
    // Fill to capacity, then overflow
    for (int i = 0; i < CAPACITY; i++)
      send_op(KIND_APPEND, VALUE_BITS'(i), 4'd0, 1'(i));
    send_op(KIND_APPEND, 4'hF, 4'hF, 1'b1);
    // Read the tail, remove the head, remove the tail by value
    send_op(KIND_GET_POS, 4'd0, 4'd15, 1'b0);
    send_op(KIND_GET_POS, 4'd0, 4'd0, 1'b1);
    send_op(KIND_GET_VAL, 4'hF, 4'd0, 1'b1);
    // Key already removed, position past the count, clear with remove set
    send_op(KIND_GET_VAL, 4'd0, 4'd0, 1'b0);
    send_op(KIND_GET_POS, 4'd0, 4'd14, 1'b1);
    send_op(KIND_CLEAR, 4'hF, 4'hF, 1'b1);
    wait_drained();

    // Random phases with varying fill pressure and key spread
    for (int phase = 0; phase < 8; phase++) begin
      idle_on = (phase % 3 != 1);
      case (phase % 4)
        0: append_pct = 65;
        1: append_pct = 45;
        2: append_pct = 35;
        default: append_pct = 55;
      endcase
      key_span = (phase % 2 == 1) ? 3 : 15;
      for (int n = 0; n < 203; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < append_pct)
          kind = KIND_APPEND;
        else if (pick < 97)
          kind = $urandom_range(0, 1) ? KIND_GET_POS : KIND_GET_VAL;
        else
          kind = KIND_CLEAR;
        val = VALUE_BITS'($urandom_range(0, key_span));
        pos = $urandom_range(0, 1) ? POS_W'($urandom_range(0, 3))
                                   : POS_W'($urandom_range(0, 15));
        send_op(kind, val, pos, 1'($urandom_range(0, 1)));
      end
      wait_drained();
    end

    // Let any stray beat show up before the verdict
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("testbench: errors");
    $finish;
  end

endmodule
